>>> rtl/dice_bigram_similarity_macros.svh
// assertion macros shared by the similarity block
`ifndef DICE_BIGRAM_SIMILARITY_MACROS_SVH
`define DICE_BIGRAM_SIMILARITY_MACROS_SVH

// same-cycle implication, checked outside reset
`define DBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dbs_pkg.sv
// types and constants of the bigram similarity block
package dbs_pkg;

  // character and table geometry
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IDX_W       = 2 * CHAR_WIDTH;
  localparam int unsigned TABLE_DEPTH = 1 << IDX_W;
  localparam int unsigned FLAG_W      = 2;

  // counters and score
  localparam int unsigned CNT_W = 17;
  localparam int unsigned DEN_W = CNT_W + 1;
  localparam int unsigned REM_W = DEN_W + 1;
  localparam logic [CNT_W-1:0] SCORE_ONE = CNT_W'(1) << (CNT_W - 1);

  // divider sequencing: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = CNT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // length saturates at two
  localparam logic [1:0] LEN_ONE = 2'd1;
  localparam logic [1:0] LEN_TWO = 2'd2;

  // flag bits of one table entry
  localparam logic [FLAG_W-1:0] FLAG_FIRST  = 2'b01;
  localparam logic [FLAG_W-1:0] FLAG_SECOND = 2'b10;

  typedef enum logic [1:0] {
    KIND_FIRST   = 2'd0,
    KIND_SECOND  = 2'd1,
    KIND_COMPARE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_RESULT
  } state_e;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // flag table write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [FLAG_W-1:0] data;
  } mem_wr_t;

endpackage

>>> rtl/dbs_flag_mem.sv
// bigram presence table, one write and one registered read per cycle
module dbs_flag_mem (
  input  logic                      clk_i,
  input  dbs_pkg::mem_wr_t          wr_i,
  input  logic                      rd_en_i,
  input  logic [dbs_pkg::IDX_W-1:0] rd_addr_i,
  output logic [dbs_pkg::FLAG_W-1:0] rd_data_o
);
  import dbs_pkg::*;

  logic [FLAG_W-1:0] mem_q [TABLE_DEPTH];
  logic [FLAG_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/dbs_div.sv
// restoring divider, one quotient bit per cycle
module dbs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dbs_pkg::CNT_W-1:0] shared_i,
  input  logic [dbs_pkg::DEN_W-1:0] den_i,
  output dbs_pkg::div_stat_t        stat_o,
  output logic [dbs_pkg::CNT_W-1:0] quo_o
);
  import dbs_pkg::*;

  logic [REM_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     quo_q, quo_d;
  logic [DEN_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [REM_W-1:0]     shifted;
  logic [REM_W-1:0]     den_ext;
  logic                 fits;

  // one shift, compare and subtract step
  assign shifted = {rem_q[REM_W-2:0], 1'b0};
  assign den_ext = {1'b0, den_q};
  assign fits    = (shifted >= den_ext);

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // dividend is shared << 17, so the remainder starts at shared
      rem_d  = REM_W'(shared_i);
      quo_d  = '0;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (shifted - den_ext) : shifted;
      quo_d = {quo_q[CNT_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

>>> rtl/dice_bigram_similarity.sv
// character transfer: accept, then read-modify-write of the flag table
// compare transfer: accept, then 17 divider steps and the done flag when both strings
// have bigrams, the result register load when the output is free, then a 65536-entry clear
// the clear pass writes one table entry per cycle; input is stalled meanwhile
// after reset the same clear of all 65536 entries runs before the first input transfer
// the result register holds a finished score while the next string pair is taken
module dice_bigram_similarity (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 kind_i,
  input  logic [dbs_pkg::BYTE_W-1:0] char_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [dbs_pkg::CNT_W-1:0]  score_o,
  output logic [dbs_pkg::CNT_W-1:0]  common_count_o,
  output logic [dbs_pkg::CNT_W-1:0]  unique_first_o,
  output logic [dbs_pkg::CNT_W-1:0]  unique_second_o
);
  import dbs_pkg::*;

  `include "dice_bigram_similarity_macros.svh"

  state_e state_q, state_d;

  logic [CHAR_WIDTH-1:0] prev_a_q, prev_b_q;
  logic [1:0]            len_a_q, len_b_q;
  logic [CNT_W-1:0]      dist_a_q, dist_b_q, shared_q;
  logic [IDX_W-1:0]      clr_addr_q;
  logic                  lookup_q;
  logic                  side_q;
  logic [IDX_W-1:0]      idx_q;

  logic                  out_valid_q;
  logic [CNT_W-1:0]      score_q, common_q, uniq_a_q, uniq_b_q;

  logic                  in_accept;
  logic                  is_first, is_second, is_compare;
  logic [CHAR_WIDTH-1:0] chr;
  logic [IDX_W-1:0]      rd_addr;
  logic                  rd_en;
  logic [FLAG_W-1:0]     rd_flags;
  mem_wr_t               mem_wr;
  logic [FLAG_W-1:0]     own_mask;
  logic                  own_hit, other_hit, fresh;
  logic                  both_short, one_short, both_long, strings_eq;
  logic [DEN_W-1:0]      den;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [CNT_W-1:0]      div_quo;
  logic [CNT_W-1:0]      score_sel;
  logic                  out_free;
  logic                  load_out;
  logic                  clr_last;

  // decode of the incoming transfer
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_first   = (kind_i == KIND_FIRST);
  assign is_second  = (kind_i == KIND_SECOND);
  assign is_compare = (kind_i == KIND_COMPARE);
  assign chr        = char_byte_i[CHAR_WIDTH-1:0];

  // lookup address from the previous character of the same string
  assign rd_addr = is_second ? {prev_b_q, chr} : {prev_a_q, chr};
  assign rd_en   = in_accept && (is_first || is_second);

  // string length classes
  assign both_short = (len_a_q < LEN_TWO) && (len_b_q < LEN_TWO);
  assign one_short  = (len_a_q < LEN_TWO) || (len_b_q < LEN_TWO);
  assign both_long  = !one_short;
  assign strings_eq = (len_a_q == len_b_q) && ((len_a_q == '0) || (prev_a_q == prev_b_q));
  assign den        = {1'b0, dist_a_q} + {1'b0, dist_b_q};

  // flag update of one bigram
  assign own_mask  = side_q ? FLAG_SECOND : FLAG_FIRST;
  assign own_hit   = |(rd_flags & own_mask);
  assign other_hit = |(rd_flags & ~own_mask);
  assign fresh     = lookup_q && !own_hit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign clr_last = (clr_addr_q == '1);

  // score selection including the short-string cases
  always_comb begin
    if (both_short) begin
      score_sel = strings_eq ? SCORE_ONE : '0;
    end else if (one_short || (den == '0)) begin
      score_sel = '0;
    end else if (div_quo > SCORE_ONE) begin
      score_sel = SCORE_ONE;
    end else begin
      score_sel = div_quo;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (is_first || is_second) begin
            state_d = ST_UPDATE;
          end else if (is_compare) begin
            state_d = both_long ? ST_DIVIDE : ST_RESULT;
          end
        end
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    mem_wr.en   = 1'b0;
    mem_wr.addr = idx_q;
    mem_wr.data = rd_flags | own_mask;
    div_start   = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_addr_q;
        mem_wr.data = '0;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_valid_i && is_compare && both_long;
      end
      ST_UPDATE: begin
        mem_wr.en = fresh;
      end
      ST_RESULT: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // control state, string registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      prev_a_q    <= '0;
      prev_b_q    <= '0;
      len_a_q     <= '0;
      len_b_q     <= '0;
      dist_a_q    <= '0;
      dist_b_q    <= '0;
      shared_q    <= '0;
      lookup_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // clear sweep address wraps back to zero at the end
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + IDX_W'(1);
      end

      // character transfer: remember the character and extend the length
      if (in_accept && is_first) begin
        prev_a_q <= chr;
        lookup_q <= (len_a_q >= LEN_ONE);
        len_a_q  <= (len_a_q == LEN_TWO) ? LEN_TWO : len_a_q + 2'd1;
      end
      if (in_accept && is_second) begin
        prev_b_q <= chr;
        lookup_q <= (len_b_q >= LEN_ONE);
        len_b_q  <= (len_b_q == LEN_TWO) ? LEN_TWO : len_b_q + 2'd1;
      end

      // count a bigram new to its string
      if ((state_q == ST_UPDATE) && fresh) begin
        if (side_q) begin
          dist_b_q <= dist_b_q + CNT_W'(1);
        end else begin
          dist_a_q <= dist_a_q + CNT_W'(1);
        end
        if (other_hit) begin
          shared_q <= shared_q + CNT_W'(1);
        end
      end

      // result loaded: back to the empty-string state
      if (load_out) begin
        prev_a_q <= '0;
        prev_b_q <= '0;
        len_a_q  <= '0;
        len_b_q  <= '0;
        dist_a_q <= '0;
        dist_b_q <= '0;
        shared_q <= '0;
      end

      // output register handshake
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // lookup payload and result payload
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      side_q <= is_second;
      idx_q  <= rd_addr;
    end
    if (load_out) begin
      score_q  <= score_sel;
      common_q <= shared_q;
      uniq_a_q <= dist_a_q;
      uniq_b_q <= dist_b_q;
    end
  end

  dbs_flag_mem u_flag_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_flags)
  );

  dbs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .shared_i (shared_q),
    .den_i    (den),
    .stat_o   (div_stat),
    .quo_o    (div_quo)
  );

  assign out_valid_o     = out_valid_q;
  assign score_o         = score_q;
  assign common_count_o  = common_q;
  assign unique_first_o  = uniq_a_q;
  assign unique_second_o = uniq_b_q;

  // checks
  `DBS_ASSERT_IMP(a_shared_le_a, 1'b1, shared_q <= dist_a_q, "shared above first count")
  `DBS_ASSERT_IMP(a_shared_le_b, 1'b1, shared_q <= dist_b_q, "shared above second count")
  `DBS_ASSERT_NXT(a_compare_divides, div_start, state_q == ST_DIVIDE && div_stat.busy, "no divide")
  `DBS_ASSERT_IMP(a_quotient_range, div_stat.done, div_quo <= SCORE_ONE, "quotient above one")
  `DBS_ASSERT_IMP(a_clear_quiet, state_q == ST_CLEAR, !div_stat.busy && in_stall_o, "clear disturbed")

endmodule

>>> test/tb_top.sv
// self-checking testbench of the bigram dice similarity block
`timescale 1ns / 100ps

module tb_top;
  import dbs_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_ITEMS  = 950;
  // the code left free by the kind field, which the block must ignore
  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MASK = '1;

  typedef struct {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] char_byte;
  } symbol_t;

  typedef struct {
    logic [CNT_W-1:0] score;
    logic [CNT_W-1:0] common_count;
    logic [CNT_W-1:0] unique_first;
    logic [CNT_W-1:0] unique_second;
  } dice_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        kind = KIND_FIRST;
  logic [BYTE_W-1:0] char_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CNT_W-1:0]  score;
  logic [CNT_W-1:0]  common_count;
  logic [CNT_W-1:0]  unique_first;
  logic [CNT_W-1:0]  unique_second;

  dice_bigram_similarity dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .char_byte_i     (char_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .score_o         (score),
    .common_count_o  (common_count),
    .unique_first_o  (unique_first),
    .unique_second_o (unique_second)
  );

  always #HALF_PERIOD clk = ~clk;

  // symbols waiting to be driven and dice results waiting to come out
  symbol_t   pending_symbols[$];
  dice_rec_t expected_dice[$];

  // predictor state for the current pair of strings
  logic [FLAG_W-1:0]     bigram_seen[int unsigned];
  logic [CHAR_WIDTH-1:0] prev_first  = '0;
  logic [CHAR_WIDTH-1:0] prev_second = '0;
  logic [1:0]            len_first   = '0;
  logic [1:0]            len_second  = '0;
  logic [CNT_W-1:0]      uniq_first  = '0;
  logic [CNT_W-1:0]      uniq_second = '0;
  logic [CNT_W-1:0]      common_hits = '0;

  int mismatches    = 0;
  int chars_sent    = 0;
  int compares_sent = 0;
  int full_scores   = 0;
  int zero_scores   = 0;
  int gap_left      = 0;
  int burst_left    = 0;
  int stall_left    = 0;
  bit stall_now     = 1'b0;

  // fold one character into its string's bigram set
  task automatic absorb_char(input bit side, input logic [CHAR_WIDTH-1:0] c);
    logic [FLAG_W-1:0] own;
    logic [FLAG_W-1:0] other;
    logic [FLAG_W-1:0] f;
    logic [IDX_W-1:0]  idx;
    own   = side ? FLAG_SECOND : FLAG_FIRST;
    other = side ? FLAG_FIRST : FLAG_SECOND;
    if ((side ? len_second : len_first) >= LEN_ONE) begin
      idx = {(side ? prev_second : prev_first), c};
      f = bigram_seen.exists(idx) ? bigram_seen[idx] : '0;
      if ((f & own) == '0) begin
        bigram_seen[idx] = f | own;
        if (side) uniq_second = uniq_second + 1'b1;
        else uniq_first = uniq_first + 1'b1;
        if ((f & other) != '0) common_hits = common_hits + 1'b1;
      end
    end
    if (side) begin
      prev_second = c;
      if (len_second < LEN_TWO) len_second = len_second + 1'b1;
    end else begin
      prev_first = c;
      if (len_first < LEN_TWO) len_first = len_first + 1'b1;
    end
  endtask

  // dice score of the current pair, then start afresh
  task automatic score_pair(output dice_rec_t r);
    longint unsigned den;
    longint unsigned q;
    q = 0;
    if (len_first < LEN_TWO && len_second < LEN_TWO) begin
      if (len_first == len_second && (len_first == '0 || prev_first == prev_second))
        q = SCORE_ONE;
    end else if (len_first >= LEN_TWO && len_second >= LEN_TWO) begin
      den = longint'(uniq_first) + longint'(uniq_second);
      if (den != 0) q = (longint'(common_hits) * 2 * longint'(SCORE_ONE)) / den;
      if (q > SCORE_ONE) q = SCORE_ONE;
    end
    r.score         = q[CNT_W-1:0];
    r.common_count  = common_hits;
    r.unique_first  = uniq_first;
    r.unique_second = uniq_second;
    bigram_seen.delete();
    prev_first  = '0;
    prev_second = '0;
    len_first   = '0;
    len_second  = '0;
    uniq_first  = '0;
    uniq_second = '0;
    common_hits = '0;
  endtask

  task automatic queue_symbol(input logic [1:0] k, input logic [BYTE_W-1:0] b);
    symbol_t s;
    s.kind = k;
    s.char_byte = b;
    pending_symbols = {pending_symbols, s};
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin : driver
    dice_rec_t r;
    symbol_t   s;
    logic      nxt_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_FIRST:   begin absorb_char(1'b0, char_byte[CHAR_WIDTH-1:0] & CHAR_MASK);
                          chars_sent++; end
          KIND_SECOND:  begin absorb_char(1'b1, char_byte[CHAR_WIDTH-1:0] & CHAR_MASK);
                          chars_sent++; end
          KIND_COMPARE: begin
            score_pair(r);
            expected_dice = {expected_dice, r};
            compares_sent++;
          end
          default: ;
        endcase
      end
      nxt_valid = in_valid;
      if (!(in_valid && in_stall)) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_symbols.size() != 0) begin
          s = pending_symbols.pop_front();
          nxt_valid = 1'b1;
          kind <= s.kind;
          char_byte <= s.char_byte;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor: own stall pattern, checks each result transfer
  always @(posedge clk) begin : monitor
    dice_rec_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_dice.size() == 0) begin
          $error("result with no compare pending: score %0d", score);
          mismatches++;
        end else begin
          e = expected_dice.pop_front();
          check_field("score", e.score, score);
          check_field("common_count", e.common_count, common_count);
          check_field("unique_first", e.unique_first, unique_first);
          check_field("unique_second", e.unique_second, unique_second);
          if (e.score == SCORE_ONE) full_scores++;
          if (e.score == '0) zero_scores++;
        end
      end
      if (stall_left == 0) begin
        stall_now = ($urandom_range(0, 2) == 0);
        stall_left = stall_now ? $urandom_range(1, 30) : $urandom_range(1, 60);
      end else begin
        stall_left--;
      end
      out_stall <= stall_now;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [BYTE_W-1:0] str_a[$];
    logic [BYTE_W-1:0] str_b[$];
    logic [BYTE_W-1:0] base;
    int counted;
    int la;
    int lb;
    int ia;
    int ib;
    int mode;
    int n;

    // both strings empty
    queue_symbol(KIND_COMPARE, 8'h00);
    // single equal characters
    queue_symbol(KIND_FIRST, 8'h78);
    queue_symbol(KIND_SECOND, 8'h78);
    queue_symbol(KIND_COMPARE, 8'h00);
    // single characters that differ, extremes of the byte
    queue_symbol(KIND_FIRST, 8'h00);
    queue_symbol(KIND_SECOND, 8'hFF);
    queue_symbol(KIND_COMPARE, 8'hFF);
    // one single character against an empty string
    queue_symbol(KIND_FIRST, 8'h61);
    queue_symbol(KIND_COMPARE, 8'h00);
    // all-ones bigram in both strings, with an ignored item in between
    queue_symbol(KIND_FIRST, 8'hFF);
    queue_symbol(KIND_SECOND, 8'hFF);
    queue_symbol(KIND_FIRST, 8'hFF);
    queue_symbol(KIND_IGNORED, 8'hFF);
    queue_symbol(KIND_SECOND, 8'hFF);
    queue_symbol(KIND_FIRST, 8'hFF);
    queue_symbol(KIND_COMPARE, 8'h00);
    // only one string shorter than two
    queue_symbol(KIND_SECOND, 8'h61);
    queue_symbol(KIND_SECOND, 8'h62);
    queue_symbol(KIND_FIRST, 8'h63);
    queue_symbol(KIND_COMPARE, 8'h00);
    // partial overlap: half score
    queue_symbol(KIND_FIRST, 8'h55);
    queue_symbol(KIND_SECOND, 8'h55);
    queue_symbol(KIND_FIRST, 8'hAA);
    queue_symbol(KIND_SECOND, 8'hAA);
    queue_symbol(KIND_FIRST, 8'h55);
    queue_symbol(KIND_SECOND, 8'hAA);
    queue_symbol(KIND_COMPARE, 8'h00);

    // random string pairs, interleaved, ending in a compare
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      str_a.delete();
      str_b.delete();
      mode = $urandom_range(0, 3);
      base = BYTE_W'($urandom_range(0, 255));
      la = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 24);
      for (int i = 0; i < la; i++)
        str_a = {str_a, (mode == 1) ? BYTE_W'($urandom_range(0, 255))
                                    : BYTE_W'(base + $urandom_range(0, 3))};
      if (mode >= 2) begin
        // second string a copy of the first, lightly edited unless identical
        str_b = str_a;
        n = (mode == 2) ? $urandom_range(0, 3) : 0;
        for (int i = 0; i < n && str_b.size() != 0; i++)
          str_b[$urandom_range(0, str_b.size() - 1)] = BYTE_W'($urandom_range(0, 255));
        if (mode == 2 && $urandom_range(0, 1)) str_b = {str_b, base};
      end else begin
        lb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 24);
        for (int i = 0; i < lb; i++)
          str_b = {str_b, (mode == 1) ? BYTE_W'($urandom_range(0, 255))
                                      : BYTE_W'(base + $urandom_range(0, 3))};
      end
      ia = 0;
      ib = 0;
      while (ia < str_a.size() || ib < str_b.size()) begin
        if (ib >= str_b.size() || (ia < str_a.size() && $urandom_range(0, 1))) begin
          queue_symbol(KIND_FIRST, str_a[ia]);
          ia++;
        end else begin
          queue_symbol(KIND_SECOND, str_b[ib]);
          ib++;
        end
        counted++;
        if ($urandom_range(0, 49) == 0)
          queue_symbol(KIND_IGNORED, BYTE_W'($urandom_range(0, 255)));
      end
      queue_symbol(KIND_COMPARE, BYTE_W'($urandom_range(0, 255)));
      counted++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_symbols.size() != 0 || in_valid) @(posedge clk);
    while (expected_dice.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters over %0d string pairs", chars_sent, compares_sent);
    $display("scores seen: %0d full matches, %0d zero, %0d in between", full_scores,
             zero_scores, compares_sent - full_scores - zero_scores);
    if (mismatches == 0 && expected_dice.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // each compare costs a full table clear, so the guard is long
  initial begin : watchdog
    repeat (40) #100_000_000;
    $display("timeout with %0d results outstanding", expected_dice.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
